// File: rtl/tpi_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package tpi_pkg;

  localparam int NODES       = 64;
  localparam int NODE_AW     = (NODES > 1) ? $clog2(NODES) : 1;
  localparam int TRACE_DEPTH = 4096;
  localparam int EV_AW       = (TRACE_DEPTH > 1) ? $clog2(TRACE_DEPTH) : 1;
  localparam int CNT_W       = $clog2(TRACE_DEPTH + 1);

  localparam logic [1:0] MODE_LOAD   = 2'd0;
  localparam logic [1:0] MODE_TEST   = 2'd1;
  localparam logic [1:0] MODE_REWIND = 2'd2;

  localparam logic       STATUS_OK   = 1'b0;
  localparam logic       STATUS_FULL = 1'b1;

  typedef struct packed {
    logic [31:0] cycle;
    logic [5:0]  src;
    logic [5:0]  dst;
    logic [7:0]  flits;
  } event_t;

  typedef struct packed {
    logic [CNT_W-1:0] cnt;
    logic [5:0]       dest;
    logic [7:0]       flits;
  } node_ent_t;

  typedef struct packed {
    logic               en;
    logic [NODE_AW-1:0] addr;
    node_ent_t          data;
  } node_wr_t;

  typedef struct packed {
    logic      vld;
    node_ent_t ent;
  } node_rd_t;

  function automatic logic node_ok(input logic [5:0] n);
    return (32'(n) < 32'(NODES));
  endfunction

endpackage

`default_nettype wire

// File: rtl/tpi_node_tbl.sv
`timescale 1ns / 1ps
`default_nettype none

// per-node pending count and first event, with one valid bit per entry
module tpi_node_tbl (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        clr,
  input  logic                        rd_en,
  input  logic [tpi_pkg::NODE_AW-1:0] rd_addr,
  input  tpi_pkg::node_wr_t           wr,
  output tpi_pkg::node_rd_t           rd
);
  import tpi_pkg::*;

  node_ent_t        mem [NODES];
  logic [NODES-1:0] vld_r;
  node_ent_t        q_r;
  logic             q_vld_r;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    if (rd_en) begin
      q_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r   <= '0;
      q_vld_r <= 1'b0;
    end else begin
      if (clr) begin
        vld_r <= '0;
      end else if (wr.en) begin
        vld_r[wr.addr] <= 1'b1;
      end
      if (rd_en) begin
        q_vld_r <= vld_r[rd_addr];
      end
    end
  end

  // entry not written since the last clear reads as no events
  always_comb begin
    rd.vld       = q_vld_r;
    rd.ent.cnt   = q_vld_r ? q_r.cnt : '0;
    rd.ent.dest  = q_r.dest;
    rd.ent.flits = q_r.flits;
  end

endmodule

`default_nettype wire

// File: rtl/trace_packet_injector.sv
// trace-driven packet injector. pulse start with busy low to hand in one beat:
// load appends an event to the trace store (status full when the store
// already holds TRACE_DEPTH events), rewind clears the scan position and the
// per-node counts, test answers whether the node fires at the given cycle
// and, if it fires, takes one pending event off it. a test for the cycle
// already built is a single lookup in the node table. a test for a new cycle
// first walks the trace store from the scan position, each event costing one
// read of the trace store and, for counted events, one read-modify-write of
// the node table; the walk ends at the first event newer than the cycle or
// at the end of the stored events. every beat gives exactly one result,
// shown on the out_ ports for the single cycle that out_valid is high; the
// receiver cannot stall, so results must be taken when they appear. events
// must be loaded sorted by cycle and source.
`timescale 1ns / 1ps
`default_nettype none

module trace_packet_injector (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  output logic       busy,
  input  logic [1:0] in_mode,
  input  logic [31:0] in_cycle,
  input  logic [5:0] in_node,
  input  logic [5:0] in_dest_node,
  input  logic [7:0] in_flits,
  output logic       out_valid,
  output logic       out_fire,
  output logic [5:0] out_packet_dest,
  output logic [7:0] out_packet_flits,
  output logic       out_status
);
  import tpi_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN_RD,
    ST_SCAN_EV,
    ST_NODE_UPD,
    ST_LOOKUP
  } state_t;

  state_t           state_r;
  logic [CNT_W-1:0] event_count_r;
  logic [CNT_W-1:0] scan_pos_r;
  logic [CNT_W-1:0] idx_r;
  logic [31:0]      built_cycle_r;
  logic             built_valid_r;
  logic             counting_r;
  logic [5:0]       node_r;

  logic             out_valid_r;
  logic             out_fire_r;
  logic [5:0]       out_packet_dest_r;
  logic [7:0]       out_packet_flits_r;
  logic             out_status_r;

  // trace store
  event_t           ev_mem [TRACE_DEPTH];
  event_t           ev_q_r;
  logic             ev_rd_en;
  logic             ev_wr_en;
  event_t           ev_wr_data;

  // node table access
  logic             node_clr;
  logic             node_rd_en;
  logic [NODE_AW-1:0] node_rd_addr;
  node_wr_t         node_wr;
  node_rd_t         node_rd;

  logic             accept;
  logic             store_full;
  logic             same_built;
  logic             idx_end;
  logic             ev_older;
  logic             ev_equal;
  logic             fire_now;

  assign accept     = start && (state_r == ST_IDLE);
  assign busy       = (state_r != ST_IDLE);
  assign store_full = (event_count_r == CNT_W'(TRACE_DEPTH));
  assign same_built = built_valid_r && (built_cycle_r == in_cycle);
  assign idx_end    = (idx_r >= event_count_r);
  assign ev_older   = (ev_q_r.cycle < built_cycle_r);
  assign ev_equal   = (ev_q_r.cycle == built_cycle_r);
  assign fire_now   = node_ok(node_r) && node_rd.vld && (node_rd.ent.cnt != '0);

  // load beat writes the next free slot, flits raised to at least one
  assign ev_wr_en         = accept && (in_mode == MODE_LOAD) && !store_full;
  assign ev_wr_data.cycle = in_cycle;
  assign ev_wr_data.src   = in_node;
  assign ev_wr_data.dst   = in_dest_node;
  assign ev_wr_data.flits = (in_flits == 8'd0) ? 8'd1 : in_flits;
  assign ev_rd_en         = (state_r == ST_SCAN_RD) && !idx_end;

  always_ff @(posedge clk) begin
    if (ev_wr_en) begin
      ev_mem[event_count_r[EV_AW-1:0]] <= ev_wr_data;
    end
    if (ev_rd_en) begin
      ev_q_r <= ev_mem[idx_r[EV_AW-1:0]];
    end
  end

  // node table read port: the tested node for a lookup, the event source
  // while counting
  always_comb begin
    node_clr     = accept && ((in_mode == MODE_REWIND) ||
                              ((in_mode == MODE_TEST) && !same_built));
    node_rd_en   = 1'b0;
    node_rd_addr = node_r[NODE_AW-1:0];
    unique case (state_r)
      ST_IDLE: begin
        if (accept && (in_mode == MODE_TEST) && same_built) begin
          node_rd_en   = 1'b1;
          node_rd_addr = in_node[NODE_AW-1:0];
        end
      end
      ST_SCAN_RD: begin
        node_rd_en = idx_end;
      end
      ST_SCAN_EV: begin
        if (!(!counting_r && ev_older)) begin
          if (ev_equal) begin
            node_rd_en   = node_ok(ev_q_r.src);
            node_rd_addr = ev_q_r.src[NODE_AW-1:0];
          end else begin
            node_rd_en = 1'b1;
          end
        end
      end
      default: ;
    endcase
  end

  // event count up (first keeps dest and size), or down on a firing lookup
  always_comb begin
    node_wr = '0;
    if (state_r == ST_NODE_UPD) begin
      node_wr.en         = 1'b1;
      node_wr.addr       = ev_q_r.src[NODE_AW-1:0];
      node_wr.data.cnt   = node_rd.ent.cnt + CNT_W'(1);
      node_wr.data.dest  = node_rd.vld ? node_rd.ent.dest  : ev_q_r.dst;
      node_wr.data.flits = node_rd.vld ? node_rd.ent.flits : ev_q_r.flits;
    end else if ((state_r == ST_LOOKUP) && fire_now) begin
      node_wr.en         = 1'b1;
      node_wr.addr       = node_r[NODE_AW-1:0];
      node_wr.data.cnt   = node_rd.ent.cnt - CNT_W'(1);
      node_wr.data.dest  = node_rd.ent.dest;
      node_wr.data.flits = node_rd.ent.flits;
    end
  end

  tpi_node_tbl u_node_tbl (
    .clk     (clk),
    .rst_n   (rst_n),
    .clr     (node_clr),
    .rd_en   (node_rd_en),
    .rd_addr (node_rd_addr),
    .wr      (node_wr),
    .rd      (node_rd)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r            <= ST_IDLE;
      event_count_r      <= '0;
      scan_pos_r         <= '0;
      idx_r              <= '0;
      built_cycle_r      <= '0;
      built_valid_r      <= 1'b0;
      counting_r         <= 1'b0;
      node_r             <= '0;
      out_valid_r        <= 1'b0;
      out_fire_r         <= 1'b0;
      out_packet_dest_r  <= '0;
      out_packet_flits_r <= '0;
      out_status_r       <= STATUS_OK;
    end else begin
      out_valid_r <= 1'b0;
      unique case (state_r)
        ST_IDLE: begin
          if (accept) begin
            node_r <= in_node;
            unique case (in_mode)
              MODE_LOAD: begin
                out_valid_r        <= 1'b1;
                out_fire_r         <= 1'b0;
                out_packet_dest_r  <= '0;
                out_packet_flits_r <= '0;
                out_status_r       <= store_full ? STATUS_FULL : STATUS_OK;
                if (!store_full) begin
                  event_count_r <= event_count_r + CNT_W'(1);
                end
              end
              MODE_TEST: begin
                if (same_built) begin
                  state_r <= ST_LOOKUP;
                end else begin
                  // new cycle: counts cleared, walk from the scan position
                  built_valid_r <= 1'b1;
                  built_cycle_r <= in_cycle;
                  idx_r         <= scan_pos_r;
                  counting_r    <= 1'b0;
                  state_r       <= ST_SCAN_RD;
                end
              end
              MODE_REWIND: begin
                scan_pos_r         <= '0;
                built_valid_r      <= 1'b0;
                out_valid_r        <= 1'b1;
                out_fire_r         <= 1'b0;
                out_packet_dest_r  <= '0;
                out_packet_flits_r <= '0;
                out_status_r       <= STATUS_OK;
              end
              default: begin
                out_valid_r        <= 1'b1;
                out_fire_r         <= 1'b0;
                out_packet_dest_r  <= '0;
                out_packet_flits_r <= '0;
                out_status_r       <= STATUS_OK;
              end
            endcase
          end
        end
        ST_SCAN_RD: begin
          state_r <= idx_end ? ST_LOOKUP : ST_SCAN_EV;
        end
        ST_SCAN_EV: begin
          if (!counting_r && ev_older) begin
            // older event: skip it for good
            idx_r      <= idx_r + CNT_W'(1);
            scan_pos_r <= idx_r + CNT_W'(1);
            state_r    <= ST_SCAN_RD;
          end else if (ev_equal) begin
            counting_r <= 1'b1;
            idx_r      <= idx_r + CNT_W'(1);
            state_r    <= node_ok(ev_q_r.src) ? ST_NODE_UPD : ST_SCAN_RD;
          end else begin
            state_r <= ST_LOOKUP;
          end
        end
        ST_NODE_UPD: begin
          state_r <= ST_SCAN_RD;
        end
        ST_LOOKUP: begin
          out_valid_r  <= 1'b1;
          out_fire_r   <= fire_now;
          out_status_r <= STATUS_OK;
          if (node_ok(node_r) && node_rd.vld) begin
            out_packet_dest_r  <= node_rd.ent.dest;
            out_packet_flits_r <= node_rd.ent.flits;
          end else begin
            out_packet_dest_r  <= node_r;
            out_packet_flits_r <= 8'd1;
          end
          state_r <= ST_IDLE;
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid        = out_valid_r;
  assign out_fire         = out_fire_r;
  assign out_packet_dest  = out_packet_dest_r;
  assign out_packet_flits = out_packet_flits_r;
  assign out_status       = out_status_r;

  // every result lands while the sequencer is back in idle
  a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result shown while busy");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    event_count_r <= CNT_W'(TRACE_DEPTH))
    else $error("event count past store depth");

  a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
    scan_pos_r <= event_count_r)
    else $error("scan position past stored events");

  a_walk_order: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_IDLE && state_r != ST_LOOKUP) |-> idx_r >= scan_pos_r)
    else $error("walk index behind scan position");

  a_quick_result: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_mode != MODE_TEST) |=> out_valid)
    else $error("load or rewind gave no result");

endmodule

`default_nettype wire
